FILE: hw/rtl/pwfd_pkg.sv
// Package with shared types, register codes and reset values for the pulse width frame decoder.
`default_nettype none

package pwfd_pkg;

    localparam int WIDTH_W = 17;

    typedef enum logic [1:0] {
        CLS_HEADER = 2'd0,
        CLS_ZERO   = 2'd1,
        CLS_ONE    = 2'd2,
        CLS_NONE   = 2'd3
    } width_class_t;

    typedef enum logic [2:0] {
        REG_ROBOT_NUMBER = 3'd0,
        REG_HEADER_MIN   = 3'd1,
        REG_HEADER_MAX   = 3'd2,
        REG_ZERO_MIN     = 3'd3,
        REG_ZERO_MAX     = 3'd4,
        REG_ONE_MIN      = 3'd5,
        REG_ONE_MAX      = 3'd6
    } cfg_index_t;

    // Window bounds in 25 MHz ticks
    localparam logic [WIDTH_W-1:0] HEADER_MIN_RST = 17'd55000;
    localparam logic [WIDTH_W-1:0] HEADER_MAX_RST = 17'd70000;
    localparam logic [WIDTH_W-1:0] ZERO_MIN_RST   = 17'd17500;
    localparam logic [WIDTH_W-1:0] ZERO_MAX_RST   = 17'd32500;
    localparam logic [WIDTH_W-1:0] ONE_MIN_RST    = 17'd35000;
    localparam logic [WIDTH_W-1:0] ONE_MAX_RST    = 17'd50000;

    localparam logic [3:0] BIT_INDEX_RST = 4'd13;
    localparam logic [5:0] SPEED_RST     = 6'd40;
    localparam logic [2:0] TYPE_SPEED    = 3'd0;
    localparam logic [2:0] TYPE_MAX      = 3'd4;

    typedef struct packed {
        logic [WIDTH_W-1:0] header_min;
        logic [WIDTH_W-1:0] header_max;
        logic [WIDTH_W-1:0] zero_min;
        logic [WIDTH_W-1:0] zero_max;
        logic [WIDTH_W-1:0] one_min;
        logic [WIDTH_W-1:0] one_max;
    } windows_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pwfd_classify.sv
// Window comparators that sort one pulse width into header, zero, one or unrecognized.
`default_nettype none

module pwfd_classify (
    input  wire logic [pwfd_pkg::WIDTH_W-1:0] pulse_width,
    input  wire pwfd_pkg::windows_t           windows,
    output pwfd_pkg::width_class_t            width_class
);

    logic hit_header;
    logic hit_zero;
    logic hit_one;

    // Inclusive windows; an empty window (min above max) never hits
    assign hit_header = (pulse_width >= windows.header_min) && (pulse_width <= windows.header_max);
    assign hit_zero   = (pulse_width >= windows.zero_min) && (pulse_width <= windows.zero_max);
    assign hit_one    = (pulse_width >= windows.one_min) && (pulse_width <= windows.one_max);

    always_comb
    begin
        priority if (hit_header)
        begin
            width_class = pwfd_pkg::CLS_HEADER;
        end
        else if (hit_zero)
        begin
            width_class = pwfd_pkg::CLS_ZERO;
        end
        else if (hit_one)
        begin
            width_class = pwfd_pkg::CLS_ONE;
        end
        else
        begin
            width_class = pwfd_pkg::CLS_NONE;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pulse_width_frame_decoder_core.sv
// An input register, the classify and frame update logic, and one result register
// form the whole path from an input transaction to its result on the output stream.
// Throughput: one pulse width per cycle while m_tready does not stall the output.
// Reset (rst_n, asynchronous, active low) empties both stages, loads the window and
// robot registers with their defaults, clears the frame, arms bit index 13, speed 40.
`default_nettype none

module pulse_width_frame_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [16:0] pulse_width, [23:17] zero
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tlast,   // frame_done
    output logic [39:0]      m_tdata,   // [1:0] width_class, [2] addressed, [3] applied,
                                        // [19:4] frame_bits, [22:20] mission,
                                        // [28:23] average_speed, [30:29] letter,
                                        // [35:31] destination, [39:36] zero
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    // Configuration
    logic [3:0]          robot_number_reg;
    pwfd_pkg::windows_t  windows_reg;

    // Input stage
    logic                            in_valid_reg;
    logic [pwfd_pkg::WIDTH_W-1:0]    in_width_reg;

    // Decoder state
    logic [15:0] frame_reg;
    logic [15:0] frame_next;
    logic [3:0]  bit_index_reg;
    logic [3:0]  bit_index_next;
    logic [2:0]  mission_reg;
    logic [2:0]  mission_next;
    logic [5:0]  speed_reg;
    logic [5:0]  speed_next;
    logic [1:0]  letter_reg;
    logic [1:0]  letter_next;
    logic [4:0]  destination_reg;
    logic [4:0]  destination_next;

    // Result stage
    logic        out_valid_reg;
    logic        out_last_reg;
    logic [39:0] out_data_reg;
    logic [39:0] out_data_next;

    pwfd_pkg::width_class_t width_class;
    logic        done;
    logic        addressed;
    logic        applied;
    logic [2:0]  frame_type;
    logic        out_load_ok;
    logic        advance;

    assign cfg_ready = 1'b1;

    assign out_load_ok = !out_valid_reg || m_tready;
    assign advance     = in_valid_reg && out_load_ok;
    assign s_tready    = !in_valid_reg || out_load_ok;

    pwfd_classify u_classify (
        .pulse_width (in_width_reg),
        .windows     (windows_reg),
        .width_class (width_class)
    );

    always_comb
    begin
        frame_next       = frame_reg;
        bit_index_next   = bit_index_reg;
        mission_next     = mission_reg;
        speed_next       = speed_reg;
        letter_next      = letter_reg;
        destination_next = destination_reg;
        done             = 1'b0;
        addressed        = 1'b0;
        applied          = 1'b0;

        unique case (width_class)
            pwfd_pkg::CLS_HEADER:
            begin
                frame_next[15:14] = 2'b10;
                bit_index_next    = pwfd_pkg::BIT_INDEX_RST;
            end
            pwfd_pkg::CLS_ZERO, pwfd_pkg::CLS_ONE:
            begin
                frame_next[bit_index_reg] = (width_class == pwfd_pkg::CLS_ONE);
                if (bit_index_reg == 4'd0)
                begin
                    bit_index_next = pwfd_pkg::BIT_INDEX_RST;
                    done           = 1'b1;
                end
                else
                begin
                    bit_index_next = bit_index_reg - 4'd1;
                end
            end
            default:
            begin
                // Unrecognized width: hold everything
            end
        endcase

        frame_type = frame_next[13:11];
        if (done && (frame_next[10:7] == robot_number_reg))
        begin
            addressed = 1'b1;
            if (frame_type == pwfd_pkg::TYPE_SPEED)
            begin
                mission_next = 3'd0;
                speed_next   = frame_next[5:0];
                applied      = 1'b1;
            end
            else if (frame_type <= pwfd_pkg::TYPE_MAX)
            begin
                mission_next     = frame_type;
                letter_next      = frame_next[6:5];
                destination_next = frame_next[4:0];
                applied          = 1'b1;
            end
        end

        out_data_next = {4'd0, destination_next, letter_next, speed_next, mission_next,
                         frame_next, applied, addressed, width_class};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_number_reg       <= 4'd0;
            windows_reg.header_min <= pwfd_pkg::HEADER_MIN_RST;
            windows_reg.header_max <= pwfd_pkg::HEADER_MAX_RST;
            windows_reg.zero_min   <= pwfd_pkg::ZERO_MIN_RST;
            windows_reg.zero_max   <= pwfd_pkg::ZERO_MAX_RST;
            windows_reg.one_min    <= pwfd_pkg::ONE_MIN_RST;
            windows_reg.one_max    <= pwfd_pkg::ONE_MAX_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pwfd_pkg::REG_ROBOT_NUMBER: robot_number_reg       <= cfg_data[3:0];
                pwfd_pkg::REG_HEADER_MIN:   windows_reg.header_min <= cfg_data;
                pwfd_pkg::REG_HEADER_MAX:   windows_reg.header_max <= cfg_data;
                pwfd_pkg::REG_ZERO_MIN:     windows_reg.zero_min   <= cfg_data;
                pwfd_pkg::REG_ZERO_MAX:     windows_reg.zero_max   <= cfg_data;
                pwfd_pkg::REG_ONE_MIN:      windows_reg.one_min    <= cfg_data;
                pwfd_pkg::REG_ONE_MAX:      windows_reg.one_max    <= cfg_data;
                default:
                begin
                    // Drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_last_reg    <= 1'b0;
            frame_reg       <= 16'd0;
            bit_index_reg   <= pwfd_pkg::BIT_INDEX_RST;
            mission_reg     <= 3'd0;
            speed_reg       <= pwfd_pkg::SPEED_RST;
            letter_reg      <= 2'd0;
            destination_reg <= 5'd0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load_ok)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // Commit state only as the item moves into the result register
            if (advance)
            begin
                out_last_reg    <= done;
                frame_reg       <= frame_next;
                bit_index_reg   <= bit_index_next;
                mission_reg     <= mission_next;
                speed_reg       <= speed_next;
                letter_reg      <= letter_next;
                destination_reg <= destination_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_width_reg <= s_tdata[pwfd_pkg::WIDTH_W-1:0];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pwfd_checker.sv
// Port level checks for the pulse width frame decoder, bound to the top level.
`default_nettype none

module pwfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic        m_tlast,
    input wire logic [39:0] m_tdata
);

    // A completed frame comes only from a zero or one bit
    a_last_from_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
            (m_tdata[1:0] == pwfd_pkg::CLS_ZERO || m_tdata[1:0] == pwfd_pkg::CLS_ONE))
        else $error("frame completed on a non-bit width class");

    // Addressed only on a completed frame
    a_addr_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> m_tlast)
        else $error("addressed set without frame completion");

    // Applied only for an addressed frame
    a_applied_needs_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3]) |-> m_tdata[2])
        else $error("applied set on a frame that was not addressed");

    // A header leaves the frame start pattern in the top two bits
    a_header_marks_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] == pwfd_pkg::CLS_HEADER) |-> (m_tdata[19:18] == 2'b10))
        else $error("header did not set frame bits 15:14");

    // Hold a stalled result
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output transaction changed");

endmodule

bind pulse_width_frame_decoder_core pwfd_checker u_pwfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
);

`default_nettype wire
